// ----- hw/rtl/rtz_pkg.sv -----
package rtz_pkg;

  localparam int DQ_W = 48;
  localparam int FMOD_W = 7;
  localparam int MOD_BASE = 100;
  localparam int SHADE_BASE = 155;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [47:0] prod_t;

  localparam fx_t FAR_T = 32'sh7FFFFFFF;
  localparam logic [15:0] MIN_DEN_RESET = 16'd7;
  localparam logic [1:0] VSLOT_NONE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X = 3'd0,
    CFG_CAMERA_Y = 3'd1,
    CFG_CAMERA_Z = 3'd2,
    CFG_FACE_COUNT = 3'd3,
    CFG_MIN_DEN = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_CAST = 1'b1
  } action_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t a;
    vec3_t e0;
    vec3_t e1;
  } geo_t;

  typedef struct packed {
    logic [FMOD_W-1:0] fmod;
    logic last;
    logic keep;
  } tag_t;

  typedef struct packed {
    logic valid;
    vec3_t a;
    vec3_t b;
    vec3_t c;
    tag_t tag;
  } eval_in_t;

  typedef struct packed {
    logic valid;
    logic hit;
    fx_t t;
    logic [FMOD_W-1:0] fmod;
    logic last;
  } eval_out_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [DQ_W-1:0] dq;
    logic [31:0] den;
  } div_lane_t;

  typedef struct packed {
    geo_t geo;
    tag_t tag;
    logic neg;
  } div_side_t;

  function automatic fx_t sat32(input logic signed [63:0] v);
    fx_t r;
    if (v > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 64'shFFFFFFFF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] ext32(input fx_t a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [63:0] ext48(input prod_t p);
    return {{16{p[47]}}, p};
  endfunction

  function automatic prod_t fxp(input fx_t a, input fx_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic fx_t sub_sat(input fx_t a, input fx_t b);
    return sat32(ext32(a) - ext32(b));
  endfunction

  function automatic fx_t add_sat(input fx_t a, input fx_t b);
    return sat32(ext32(a) + ext32(b));
  endfunction

  function automatic fx_t sum3(input prod_t p, input prod_t q, input prod_t r);
    return sat32(ext48(p) + ext48(q) + ext48(r));
  endfunction

  function automatic fx_t dif2(input prod_t p, input prod_t q);
    return sat32(ext48(p) - ext48(q));
  endfunction

endpackage

// ----- hw/rtl/rtz_if.sv -----
interface rtz_item_if;
  import rtz_pkg::*;
  logic valid;
  logic ready;
  logic action;
  logic [9:0] face_slot;
  logic [1:0] vertex_slot;
  fx_t coord_x;
  fx_t coord_y;
  fx_t coord_z;
  modport source(output valid, action, face_slot, vertex_slot, coord_x, coord_y, coord_z,
                 input ready);
  modport sink(input valid, action, face_slot, vertex_slot, coord_x, coord_y, coord_z,
               output ready);
endinterface

interface rtz_result_if;
  import rtz_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  logic [7:0] shade;
  fx_t depth_t;
  modport source(output valid, hit, shade, depth_t, input ready);
  modport sink(input valid, hit, shade, depth_t, output ready);
endinterface

interface rtz_cfg_if;
  import rtz_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rtz_div_cell.sv -----
module rtz_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  rtz_pkg::div_lane_t    in_lane,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output rtz_pkg::div_lane_t    out_lane,
  output logic [SIDE_W-1:0]     out_side
);
  import rtz_pkg::*;

  logic [31:0] trial;
  logic ge;

  always_comb begin
    trial = {in_lane.rem[30:0], in_lane.dq[DQ_W-1]};
    ge = (trial >= in_lane.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane.rem <= ge ? (trial - in_lane.den) : trial;
    out_lane.dq <= {in_lane.dq[DQ_W-2:0], ge};
    out_lane.den <= in_lane.den;
    out_side <= in_side;
  end

endmodule

// ----- hw/rtl/rtz_eval.sv -----
module rtz_eval (
  input  logic               clk,
  input  logic               rst,
  input  rtz_pkg::eval_in_t  src,
  input  rtz_pkg::vec3_t     cam,
  input  rtz_pkg::vec3_t     dir,
  input  logic [15:0]        min_den,
  output rtz_pkg::eval_out_t res
);
  import rtz_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic v7, v8, v9, v10, v11, v12, v13, v14;
  geo_t geo1, geo2, geo3, geo4, geo5;
  tag_t tag1, tag2, tag3, tag4, tag5;
  prod_t cx1, cx2, cy1, cy2, cz1, cz2;
  vec3_t nrm3, nn3, nrm_c;
  prod_t pa_x, pa_y, pa_z, pc_x, pc_y, pc_z, pd_x, pd_y, pd_z;
  fx_t dpl5, dcam5, den5;
  fx_t num_c;
  logic signed [63:0] num_e, mag_e, min_e;

  logic dv [0:DQ_W];
  div_lane_t dl [0:DQ_W];
  div_side_t ds [0:DQ_W];

  logic signed [63:0] q_e;
  geo_t geo7, geo8, geo9, geo10;
  tag_t tag7, tag8, tag9, tag10, tag11, tag12, tag13, tag14;
  fx_t t7, t8, t9, t10, t11, t12, t13, t14;
  prod_t pm_x, pm_y, pm_z;
  vec3_t p9, e2_10;
  prod_t q00x, q00y, q00z, q01x, q01y, q01z, q02x, q02y, q02z;
  prod_t q11x, q11y, q11z, q12x, q12y, q12z;
  fx_t d00, d01, d02, d11, d12;
  prod_t m_d1, m_d2, m_u1, m_u2, m_v1, m_v2;
  fx_t bden, bun, bvn;
  logic signed [63:0] uv_sum;
  logic in_tri;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dv[0] <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1 <= src.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dv[0] <= v5;
      v7 <= dv[DQ_W];
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      res.valid <= v14;
    end
  end

  always_comb begin
    nrm_c.x = dif2(cx1, cx2);
    nrm_c.y = dif2(cy1, cy2);
    nrm_c.z = dif2(cz1, cz2);
    num_c = sub_sat(dcam5, dpl5);
    num_e = ext32(num_c);
    mag_e = num_c[31] ? -num_e : num_e;
    min_e = {48'b0, min_den};
    q_e = {16'b0, dl[DQ_W].dq};
    uv_sum = ext32(bun) + ext32(bvn);
    in_tri = (bden > 0 && bun >= 0 && bvn >= 0 && uv_sum < ext32(bden)) ||
             (bden < 0 && bun <= 0 && bvn <= 0 && uv_sum > ext32(bden));
  end

  always_ff @(posedge clk) begin
    geo1.a <= src.a;
    geo1.e0 <= '{sub_sat(src.c.x, src.a.x), sub_sat(src.c.y, src.a.y),
                 sub_sat(src.c.z, src.a.z)};
    geo1.e1 <= '{sub_sat(src.b.x, src.a.x), sub_sat(src.b.y, src.a.y),
                 sub_sat(src.b.z, src.a.z)};
    tag1 <= src.tag;

    geo2 <= geo1;
    tag2 <= tag1;
    cx1 <= fxp(geo1.e1.y, geo1.e0.z);
    cx2 <= fxp(geo1.e1.z, geo1.e0.y);
    cy1 <= fxp(geo1.e1.z, geo1.e0.x);
    cy2 <= fxp(geo1.e1.x, geo1.e0.z);
    cz1 <= fxp(geo1.e1.x, geo1.e0.y);
    cz2 <= fxp(geo1.e1.y, geo1.e0.x);

    geo3 <= geo2;
    tag3 <= tag2;
    nrm3 <= nrm_c;
    nn3.x <= sat32(-ext32(nrm_c.x));
    nn3.y <= sat32(-ext32(nrm_c.y));
    nn3.z <= sat32(-ext32(nrm_c.z));

    geo4 <= geo3;
    tag4 <= tag3;
    pa_x <= fxp(nn3.x, geo3.a.x);
    pa_y <= fxp(nn3.y, geo3.a.y);
    pa_z <= fxp(nn3.z, geo3.a.z);
    pc_x <= fxp(nn3.x, cam.x);
    pc_y <= fxp(nn3.y, cam.y);
    pc_z <= fxp(nn3.z, cam.z);
    pd_x <= fxp(nrm3.x, dir.x);
    pd_y <= fxp(nrm3.y, dir.y);
    pd_z <= fxp(nrm3.z, dir.z);

    geo5 <= geo4;
    tag5 <= tag4;
    dpl5 <= sum3(pa_x, pa_y, pa_z);
    dcam5 <= sum3(pc_x, pc_y, pc_z);
    den5 <= sum3(pd_x, pd_y, pd_z);

    dl[0].rem <= '0;
    dl[0].dq <= {mag_e[31:0], 16'b0};
    dl[0].den <= den5;
    ds[0].geo <= geo5;
    ds[0].tag.fmod <= tag5.fmod;
    ds[0].tag.last <= tag5.last;
    ds[0].tag.keep <= (ext32(den5) > min_e);
    ds[0].neg <= num_c[31];

    geo7 <= ds[DQ_W].geo;
    tag7 <= ds[DQ_W].tag;
    t7 <= sat32(ds[DQ_W].neg ? -q_e : q_e);

    geo8 <= geo7;
    tag8 <= tag7;
    t8 <= t7;
    pm_x <= fxp(dir.x, t7);
    pm_y <= fxp(dir.y, t7);
    pm_z <= fxp(dir.z, t7);

    geo9 <= geo8;
    tag9 <= tag8;
    t9 <= t8;
    p9.x <= add_sat(cam.x, sat32(ext48(pm_x)));
    p9.y <= add_sat(cam.y, sat32(ext48(pm_y)));
    p9.z <= add_sat(cam.z, sat32(ext48(pm_z)));

    geo10 <= geo9;
    tag10 <= tag9;
    t10 <= t9;
    e2_10.x <= sub_sat(p9.x, geo9.a.x);
    e2_10.y <= sub_sat(p9.y, geo9.a.y);
    e2_10.z <= sub_sat(p9.z, geo9.a.z);

    tag11 <= tag10;
    t11 <= t10;
    q00x <= fxp(geo10.e0.x, geo10.e0.x);
    q00y <= fxp(geo10.e0.y, geo10.e0.y);
    q00z <= fxp(geo10.e0.z, geo10.e0.z);
    q01x <= fxp(geo10.e0.x, geo10.e1.x);
    q01y <= fxp(geo10.e0.y, geo10.e1.y);
    q01z <= fxp(geo10.e0.z, geo10.e1.z);
    q02x <= fxp(geo10.e0.x, e2_10.x);
    q02y <= fxp(geo10.e0.y, e2_10.y);
    q02z <= fxp(geo10.e0.z, e2_10.z);
    q11x <= fxp(geo10.e1.x, geo10.e1.x);
    q11y <= fxp(geo10.e1.y, geo10.e1.y);
    q11z <= fxp(geo10.e1.z, geo10.e1.z);
    q12x <= fxp(geo10.e1.x, e2_10.x);
    q12y <= fxp(geo10.e1.y, e2_10.y);
    q12z <= fxp(geo10.e1.z, e2_10.z);

    tag12 <= tag11;
    t12 <= t11;
    d00 <= sum3(q00x, q00y, q00z);
    d01 <= sum3(q01x, q01y, q01z);
    d02 <= sum3(q02x, q02y, q02z);
    d11 <= sum3(q11x, q11y, q11z);
    d12 <= sum3(q12x, q12y, q12z);

    tag13 <= tag12;
    t13 <= t12;
    m_d1 <= fxp(d00, d11);
    m_d2 <= fxp(d01, d01);
    m_u1 <= fxp(d11, d02);
    m_u2 <= fxp(d01, d12);
    m_v1 <= fxp(d00, d12);
    m_v2 <= fxp(d01, d02);

    tag14 <= tag13;
    t14 <= t13;
    bden <= dif2(m_d1, m_d2);
    bun <= dif2(m_u1, m_u2);
    bvn <= dif2(m_v1, m_v2);

    res.hit <= tag14.keep && in_tri;
    res.t <= t14;
    res.fmod <= tag14.fmod;
    res.last <= tag14.last;
  end

  for (genvar i = 0; i < DQ_W; i++) begin : g_div
    rtz_div_cell #(
      .SIDE_W($bits(div_side_t))
    ) u_div_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(dv[i]),
      .in_lane(dl[i]),
      .in_side(ds[i]),
      .out_valid(dv[i+1]),
      .out_lane(dl[i+1]),
      .out_side(ds[i+1])
    );
  end

endmodule

// ----- hw/rtl/ray_triangle_zbuffer_cast.sv -----
// Ray cast against a store of up to MAX_FACES triangles, keeping the nearest hit.
// The item channel carries two kinds of request. A load writes one corner of one
// triangle into the face memory and gives no result. A cast carries a point on
// the image plane and gives exactly one result on the result channel: the hit
// flag, the shade and the nearest ray parameter.
// A cast reads one face per cycle from the face memory and streams it through a
// face evaluator whose center is a row of 48 divider cells, one quotient bit each.
// The item channel is not ready from the acceptance of a cast until its result
// is placed in the output register; loads are taken one per cycle.
// Configuration is written through the cfg channel, which is always ready, and
// must only be written while no cast is in flight.
// Reset restores the configuration defaults and empties the pipeline; the face
// memory is not cleared and holds garbage until loaded. If the receiver stalls,
// the finished result waits in the output register; loads are still taken, and
// a following cast runs to completion and then waits for the register to empty.
module ray_triangle_zbuffer_cast #(
  parameter int MAX_FACES = 1024
) (
  input logic          clk,
  input logic          rst,
  rtz_item_if.sink     item,
  rtz_result_if.source result,
  rtz_cfg_if.sink      cfg
);
  import rtz_pkg::*;

  localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CW = $clog2(MAX_FACES + 1);

  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, HOLD} state_t;

  state_t state;
  fx_t cam_x, cam_y, cam_z;
  logic [10:0] face_count;
  logic [15:0] min_den;
  vec3_t cam, dir, pt;
  logic [CW-1:0] cnt, last_cnt, count_lim;
  logic [FMOD_W-1:0] fmod;
  logic acc, wr_ok;
  vec3_t mem0 [MAX_FACES];
  vec3_t mem1 [MAX_FACES];
  vec3_t mem2 [MAX_FACES];
  vec3_t rd0, rd1, rd2;
  logic rd_valid;
  tag_t rd_tag;
  eval_in_t ev_in;
  eval_out_t ev;
  logic found;
  fx_t best_t;
  logic [FMOD_W-1:0] best_mod;
  logic out_valid, out_hit;
  logic [7:0] out_shade;
  fx_t out_t;

  assign item.ready = (state == IDLE);
  assign cfg.ready = 1'b1;
  assign acc = item.valid && item.ready;
  assign pt = '{item.coord_x, item.coord_y, item.coord_z};
  assign cam = '{cam_x, cam_y, cam_z};
  assign wr_ok = (item.vertex_slot != VSLOT_NONE) && (32'(item.face_slot) < MAX_FACES);
  assign count_lim = (32'(face_count) > MAX_FACES) ? CW'(MAX_FACES) : CW'(face_count);

  assign result.valid = out_valid;
  assign result.hit = out_hit;
  assign result.shade = out_shade;
  assign result.depth_t = out_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      face_count <= '0;
      min_den <= MIN_DEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_CAMERA_X: cam_x <= cfg.data;
        CFG_CAMERA_Y: cam_y <= cfg.data;
        CFG_CAMERA_Z: cam_z <= cfg.data;
        CFG_FACE_COUNT: face_count <= cfg.data[10:0];
        CFG_MIN_DEN: min_den <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && item.action == ACT_LOAD && wr_ok) begin
      unique case (item.vertex_slot)
        2'd0: mem0[AW'(item.face_slot)] <= pt;
        2'd1: mem1[AW'(item.face_slot)] <= pt;
        2'd2: mem2[AW'(item.face_slot)] <= pt;
        default: ;
      endcase
    end
    rd0 <= mem0[cnt[AW-1:0]];
    rd1 <= mem1[cnt[AW-1:0]];
    rd2 <= mem2[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
      found <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (acc && item.action == ACT_CAST) begin
            dir.x <= sub_sat(pt.x, cam.x);
            dir.y <= sub_sat(pt.y, cam.y);
            dir.z <= sub_sat(pt.z, cam.z);
            found <= 1'b0;
            cnt <= '0;
            fmod <= '0;
            last_cnt <= count_lim - CW'(1);
            state <= (count_lim == '0) ? HOLD : ISSUE;
          end
        end
        ISSUE: begin
          rd_valid <= 1'b1;
          rd_tag.fmod <= fmod;
          rd_tag.last <= (cnt == last_cnt);
          rd_tag.keep <= 1'b0;
          cnt <= cnt + CW'(1);
          fmod <= (fmod == FMOD_W'(MOD_BASE - 1)) ? '0 : fmod + FMOD_W'(1);
          if (cnt == last_cnt) begin
            state <= WAIT;
          end
        end
        WAIT: begin
          if (ev.valid && ev.last) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_hit <= found;
            out_shade <= found ? 8'(SHADE_BASE) + 8'(best_mod) : '0;
            out_t <= found ? best_t : FAR_T;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (ev.valid && ev.hit && (!found || ev.t < best_t)) begin
        found <= 1'b1;
        best_t <= ev.t;
        best_mod <= ev.fmod;
      end
    end
  end

  always_comb begin
    ev_in.valid = rd_valid;
    ev_in.a = rd0;
    ev_in.b = rd1;
    ev_in.c = rd2;
    ev_in.tag = rd_tag;
  end

  rtz_eval u_eval (
    .clk(clk),
    .rst(rst),
    .src(ev_in),
    .cam(cam),
    .dir(dir),
    .min_den(min_den),
    .res(ev)
  );

endmodule
